// ===== rtl/core/fpl2_pkg.sv =====
// Package for the fixed-point log2 unit: widths, constants and the
// struct passed between the normaliser, the squaring step and the top level.
// No dependencies.
package fpl2_pkg;

  localparam int unsigned ValueW  = 13;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RoundW  = 16;
  localparam int unsigned OctW    = 4;

  localparam logic [DataW-1:0] BaseScaleReset = 32'd357908480;
  localparam logic [DataW-1:0] FracMask       = 32'h7FFF_FFFF;
  localparam logic [63:0]      SquareBias     = 64'h0000_0000_4000_0000;
  localparam logic [DataW-1:0] RoundBias      = 32'h0000_8000;

  typedef struct packed {
    logic [DataW-1:0] mant;
    logic [DataW-1:0] step;
    logic [DataW-1:0] acc;
  } sq_state_t;

endpackage

// ===== rtl/core/fpl2_norm.sv =====
// Normaliser of the fixed-point log2 unit: bit length of the argument,
// mantissa alignment and the integer octave part. Depends on fpl2_pkg.
module fpl2_norm import fpl2_pkg::*; (
  input  logic [ValueW-1:0] value_i,
  input  logic [DataW-1:0]  base_i,
  output sq_state_t         init_o
);

  logic [OctW-1:0]      len;
  logic [OctW-1:0]      octaves;
  logic [4:0]           shamt;
  logic [DataW+OctW-1:0] prod;

  always_comb begin
    len = '0;
    for (int i = 0; i < ValueW; i++) begin
      if (value_i[i]) begin
        len = OctW'(i + 1);
      end
    end
  end

  assign octaves = OctW'(ValueW) - len;
  assign shamt   = 5'(6'd32 - {2'b00, len});
  assign prod    = {{OctW{1'b0}}, base_i} * {{DataW{1'b0}}, octaves};

  always_comb begin
    if (len == '0) begin
      init_o.mant = '0;
      init_o.step = base_i;
      init_o.acc  = '0;
    end else begin
      init_o.mant = DataW'(value_i) << shamt;
      init_o.step = base_i;
      init_o.acc  = prod[DataW-1:0];
    end
  end

endmodule

// ===== rtl/core/fpl2_square.sv =====
// Shared squaring step of the fixed-point log2 unit: one rounded 32x32
// square of the mantissa, step halving and conditional subtract. Depends on fpl2_pkg.
module fpl2_square import fpl2_pkg::*; (
  input  sq_state_t cur_i,
  output sq_state_t nxt_o
);

  logic [63:0]      sq;
  logic [63:0]      sum;
  logic [DataW:0]   q;
  logic [DataW-1:0] half;

  assign sq   = {32'b0, cur_i.mant} * {32'b0, cur_i.mant};
  assign sum  = sq + SquareBias;
  assign q    = sum[63:31];
  assign half = cur_i.step >> 1;

  always_comb begin
    nxt_o.step = half;
    if (q[DataW]) begin
      nxt_o.acc  = cur_i.acc - half;
      nxt_o.mant = q[DataW:1];
    end else begin
      nxt_o.acc  = cur_i.acc;
      nxt_o.mant = q[DataW-1:0];
    end
  end

endmodule

// ===== rtl/core/fixed_point_log2_unit_core.sv =====
// Top level of the fixed-point log2 unit: base_scale * log2(4096 / x).
// Sequencer, configuration register and output register. Depends on fpl2_pkg,
// fpl2_norm and fpl2_square.

// An item goes from acceptance to the output register through normalisation,
// N squaring steps (at most 31, one per cycle through the single shared 32x32
// squarer, fewer when the mantissa fraction runs out or the step reaches one)
// and a finish step. A new item is taken only in the idle state, at the earliest
// in the cycle in which the previous result first sits in the output register,
// so items never overlap. A result held in the output register stalls the finish
// step. An input of zero returns zero.
module fixed_point_log2_unit_core import fpl2_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DataW-1:0]  cfg_base_scale_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DataW-1:0]  log_raw_o,
  output logic [RoundW-1:0] log_rounded_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StInit = 2'd1;
  localparam logic [1:0] StIter = 2'd2;
  localparam logic [1:0] StHold = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [DataW-1:0]  base_q;
  logic [ValueW-1:0] value_q;
  sq_state_t         st_q, st_d;
  sq_state_t         init_st, next_st;
  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  raw_q, raw_d;
  logic              cont;
  logic              out_free;
  logic              load_out;
  logic [DataW-1:0]  round_sum;

  fpl2_norm u_norm (
    .value_i (value_q),
    .base_i  (base_q),
    .init_o  (init_st)
  );

  fpl2_square u_square (
    .cur_i (st_q),
    .nxt_o (next_st)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign out_free    = !out_valid_q || out_ready_i;
  assign cont        = (st_q.step > 32'd1) && ((st_q.mant & FracMask) != '0);

  always_comb begin
    state_d  = state_q;
    st_d     = st_q;
    load_out = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StInit;
        end
      end
      StInit: begin
        st_d    = init_st;
        state_d = StIter;
      end
      StIter: begin
        if (cont) begin
          st_d = next_st;
        end else if (out_free) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end else begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    raw_d       = raw_q;
    out_valid_d = out_valid_q;
    if (load_out) begin
      raw_d       = st_q.acc;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      base_q      <= BaseScaleReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_base_scale_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    raw_q <= raw_d;
    if (in_valid_i && in_ready_o) begin
      value_q <= value_i;
    end
  end

  assign round_sum     = raw_q + RoundBias;
  assign out_valid_o   = out_valid_q;
  assign log_raw_o     = raw_q;
  assign log_rounded_o = round_sum[DataW-1:DataW-RoundW];

  a_step_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIter && cont) |=> (st_q.step < $past(st_q.step)))
    else $error("step did not shrink during squaring");

  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIter) |-> (st_q.mant[DataW-1] || st_q.mant == '0))
    else $error("mantissa left normalised range");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StIter || state_q == StHold))
    else $error("result appeared outside the finish step");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StInit && !in_ready_o))
    else $error("accepted item did not start normalisation");

endmodule
